// ----- hdl/redundant_feed_quorum_gate_macros.svh -----
// Assertion macros for the redundant feed quorum gate checker.
// No dependencies.
`ifndef REDUNDANT_FEED_QUORUM_GATE_MACROS_SVH
`define REDUNDANT_FEED_QUORUM_GATE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define RFQG_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Implication checked on every rising clock edge, reset included.
`define RFQG_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

// ----- hdl/rfqg_pkg.sv -----
// Shared types and codes for the redundant feed quorum gate.
// No dependencies.
package rfqg_pkg;
    typedef enum logic [2:0] {
        OUT_PENDING    = 3'd0,
        OUT_ACTIONABLE = 3'd1,
        OUT_DUPLICATE  = 3'd2,
        OUT_CONFLICT   = 3'd3,
        OUT_INVALID    = 3'd4,
        OUT_RANGE      = 3'd5,
        OUT_STALE      = 3'd6
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_OUT   = 2'd2
    } state_t;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_CLEAR   = 1'b1;
    localparam logic MODE_QUORUM = 1'b0;
    localparam logic MODE_SHADOW = 1'b1;
    localparam int   LANES = 3;

    // Per-instrument slot header (stored in one memory word).
    typedef struct packed {
        logic        live;       // epoch defined; 0 means empty slot
        logic [63:0] epoch;
        logic [63:0] first;
        logic [2:0]  seen;
        logic [2:0]  conf;
        logic        emitted;
    } slot_t;

    // Per-lane record.
    typedef struct packed {
        logic [63:0] bid;
        logic [63:0] ask;
        logic [63:0] arrival;
    } lane_rec_t;

    function automatic logic [1:0] count3(input logic [2:0] m);
        count3 = {1'b0, m[0]} + {1'b0, m[1]} + {1'b0, m[2]};
    endfunction
endpackage

// ----- hdl/redundant_feed_quorum_gate.sv -----
// Redundant feed quorum gate: 2-of-3 vote (quorum mode) over three best-bid/ask feed lanes.
// Transactions do not overlap: accept, slot memory read, registered result,
// set by the single read-modify-write of the slot memory; the result step
// waits while an earlier result is untaken. A clear writes the slot header
// only. After reset a clearing pass empties the slot memory before the first
// transaction is taken. Depends on rfqg_pkg and rfqg_decide.
module redundant_feed_quorum_gate #(
    parameter int INSTRUMENTS = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [0:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [1:0]         s_lane,
    input  logic               s_update_valid,
    input  logic [31:0]        s_instrument,
    input  logic signed [63:0] s_event_time,
    input  logic signed [63:0] s_receive_time,
    input  logic signed [63:0] s_bid_price,
    input  logic signed [63:0] s_ask_price,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_outcome,
    output logic [2:0]         m_observed_mask,
    output logic [2:0]         m_agreeing_mask,
    output logic [2:0]         m_conflicting_mask,
    output logic signed [63:0] m_out_bid,
    output logic signed [63:0] m_out_ask,
    output logic signed [63:0] m_out_event_time,
    output logic signed [63:0] m_out_receive_time,
    output logic [62:0]        m_epoch_first_receive,
    output logic [62:0]        m_ready_time,
    output logic [31:0]        m_out_instrument
);
    localparam int AW = $clog2(INSTRUMENTS);

    rfqg_pkg::slot_t     slot_mem [INSTRUMENTS];
    rfqg_pkg::lane_rec_t lane_mem0 [INSTRUMENTS];
    rfqg_pkg::lane_rec_t lane_mem1 [INSTRUMENTS];
    rfqg_pkg::lane_rec_t lane_mem2 [INSTRUMENTS];

    rfqg_pkg::state_t state_reg, state_next;
    logic [AW:0]      clr_reg, clr_next;
    logic             mode_reg;

    // Captured transaction
    logic              op_reg;
    logic [1:0]        lane_reg;
    logic              bad_reg, range_reg;
    logic [31:0]       inst_reg;
    logic [AW-1:0]     addr_reg;
    logic signed [63:0] ev_reg, rx_reg, bid_reg, ask_reg;

    rfqg_pkg::slot_t     slot_rd;
    rfqg_pkg::lane_rec_t rec_rd [3];
    rfqg_pkg::slot_t     slot_wr;
    logic                slot_we, lane_we;
    logic [2:0]          d_outcome, d_obs, d_agr, d_con;
    logic [63:0]         d_bid, d_ask;
    logic [62:0]         d_first, d_ready;
    logic                accept, clearing, in_addr_ok, out_fire;

    assign clearing = (clr_reg < (AW+1)'(INSTRUMENTS));
    assign s_ready  = (state_reg == rfqg_pkg::ST_IDLE) && !clearing;
    assign accept   = s_valid && s_ready;
    assign in_addr_ok = (s_instrument < 32'(INSTRUMENTS));
    // Finish the transaction once the result register is free or being taken, or at once for a clear
    assign out_fire = (state_reg == rfqg_pkg::ST_OUT) &&
                      (op_reg == rfqg_pkg::OP_CLEAR || !m_valid || m_ready);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rfqg_pkg::ST_IDLE: if (accept) state_next = rfqg_pkg::ST_READ;
            rfqg_pkg::ST_READ: state_next = rfqg_pkg::ST_OUT;
            rfqg_pkg::ST_OUT:  if (out_fire) state_next = rfqg_pkg::ST_IDLE;
            default:           state_next = rfqg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        clr_next = clearing ? clr_reg + 1'b1 : clr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rfqg_pkg::ST_IDLE;
            clr_reg   <= '0;
            mode_reg  <= rfqg_pkg::MODE_QUORUM;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_we) mode_reg <= cfg_wdata[0];
        end
    end

    // Capture the transaction
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg    <= s_op;
            lane_reg  <= s_lane;
            bad_reg   <= s_lane == 2'd3 || !s_update_valid || s_instrument == 32'd0
                         || s_event_time <= 0 || s_receive_time <= 0
                         || s_bid_price <= 0 || s_ask_price <= s_bid_price;
            range_reg <= !in_addr_ok;
            inst_reg  <= s_instrument;
            addr_reg  <= s_instrument[AW-1:0];
            ev_reg    <= s_event_time;
            rx_reg    <= s_receive_time;
            bid_reg   <= s_bid_price;
            ask_reg   <= s_ask_price;
        end
    end

    // Read slot and lane records
    always_ff @(posedge aclk) begin
        if (state_reg == rfqg_pkg::ST_READ) begin
            slot_rd   <= slot_mem[addr_reg];
            rec_rd[0] <= lane_mem0[addr_reg];
            rec_rd[1] <= lane_mem1[addr_reg];
            rec_rd[2] <= lane_mem2[addr_reg];
        end
    end

    rfqg_decide u_decide (
        .mode(mode_reg), .lane(lane_reg), .bad(bad_reg), .out_range(range_reg),
        .ev(ev_reg), .rx(rx_reg), .bid(bid_reg), .ask(ask_reg),
        .slot_in(slot_rd), .rec_in(rec_rd), .slot_out(slot_wr),
        .slot_we(slot_we), .lane_we(lane_we), .outcome(d_outcome),
        .obs(d_obs), .agr(d_agr), .con(d_con), .obid(d_bid), .oask(d_ask),
        .first(d_first), .ready(d_ready)
    );

    // Write back: clearing pass, clear op, or modified slot
    always_ff @(posedge aclk) begin
        if (clearing) begin
            slot_mem[clr_reg[AW-1:0]] <= '0;
        end else if (out_fire) begin
            if (op_reg == rfqg_pkg::OP_CLEAR) begin
                if (!bad_reg || inst_reg != 32'd0) begin
                    if (inst_reg != 32'd0 && !range_reg) slot_mem[addr_reg] <= '0;
                end
            end else if (slot_we) begin
                slot_mem[addr_reg] <= slot_wr;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_fire && op_reg == rfqg_pkg::OP_OBSERVE && lane_we) begin
            case (lane_reg)
                2'd0:    lane_mem0[addr_reg] <= {bid_reg, ask_reg, rx_reg};
                2'd1:    lane_mem1[addr_reg] <= {bid_reg, ask_reg, rx_reg};
                default: lane_mem2[addr_reg] <= {bid_reg, ask_reg, rx_reg};
            endcase
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (out_fire && op_reg == rfqg_pkg::OP_OBSERVE) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_fire && op_reg == rfqg_pkg::OP_OBSERVE) begin
            m_outcome             <= d_outcome;
            m_observed_mask       <= d_obs;
            m_agreeing_mask       <= d_agr;
            m_conflicting_mask    <= d_con;
            m_out_bid             <= d_bid;
            m_out_ask             <= d_ask;
            m_out_event_time      <= ev_reg;
            m_out_receive_time    <= rx_reg;
            m_epoch_first_receive <= d_first;
            m_ready_time          <= d_ready;
            m_out_instrument      <= inst_reg;
        end
    end
endmodule

// ----- hdl/rfqg_decide.sv -----
// Classification logic for one update against a read slot.
// Depends on rfqg_pkg.
module rfqg_decide (
    input  logic                    mode,
    input  logic [1:0]              lane,
    input  logic                    bad,
    input  logic                    out_range,
    input  logic signed [63:0]      ev,
    input  logic signed [63:0]      rx,
    input  logic signed [63:0]      bid,
    input  logic signed [63:0]      ask,
    input  rfqg_pkg::slot_t         slot_in,
    input  rfqg_pkg::lane_rec_t     rec_in [3],
    output rfqg_pkg::slot_t         slot_out,
    output logic                    slot_we,
    output logic                    lane_we,
    output logic [2:0]              outcome,
    output logic [2:0]              obs,
    output logic [2:0]              agr,
    output logic [2:0]              con,
    output logic [63:0]             obid,
    output logic [63:0]             oask,
    output logic [62:0]             first,
    output logic [62:0]             ready
);
    logic [2:0]        bit_m;
    logic [2:0]        seen2, usable, m0, m1, m2, best;
    rfqg_pkg::lane_rec_t r [3];
    logic              eq01, eq02, eq12;
    logic [1:0]        fl, rr;
    logic signed [63:0] ep;

    always_comb begin
        bit_m = 3'b001 << lane;
        ep = slot_in.epoch;
        // Merged view with the new lane record
        for (int i = 0; i < 3; i++) begin
            r[i] = rec_in[i];
            if (lane == 2'(i)) begin
                r[i].bid = bid;
                r[i].ask = ask;
                r[i].arrival = rx;
            end
        end
        seen2  = slot_in.seen | bit_m;
        usable = seen2 & ~slot_in.conf;
        eq01 = r[0].bid == r[1].bid && r[0].ask == r[1].ask;
        eq02 = r[0].bid == r[2].bid && r[0].ask == r[2].ask;
        eq12 = r[1].bid == r[2].bid && r[1].ask == r[2].ask;
        m0 = usable[0] ? {usable[2] & eq02, usable[1] & eq01, 1'b1} : 3'b000;
        m1 = usable[1] ? {usable[2] & eq12, 2'b10} : 3'b000;
        m2 = usable[2] ? 3'b100 : 3'b000;
        best = m0;
        if (rfqg_pkg::count3(m1) > rfqg_pkg::count3(best)) best = m1;
        if (rfqg_pkg::count3(m2) > rfqg_pkg::count3(best)) best = m2;
        // Only lanes seen in this epoch hold a meaningful arrival
        fl = (seen2[0] && r[0].arrival == slot_in.first) ? 2'd0 :
             (seen2[1] && r[1].arrival == slot_in.first) ? 2'd1 : 2'd2;
        rr = best[0] ? 2'd0 : (best[1] ? 2'd1 : 2'd2);

        slot_out = slot_in;
        slot_we = 1'b0;
        lane_we = 1'b0;
        outcome = rfqg_pkg::OUT_PENDING;
        obs = '0; agr = '0; con = '0;
        obid = bid; oask = ask;
        first = '0; ready = '0;
        if (bad) begin
            outcome = rfqg_pkg::OUT_INVALID;
        end else if (out_range) begin
            outcome = rfqg_pkg::OUT_RANGE;
        end else if (!slot_in.live || ep == 64'sd0 || ev > ep) begin
            // Start a new epoch
            slot_we = 1'b1;
            lane_we = 1'b1;
            slot_out.live = 1'b1;
            slot_out.epoch = ev;
            slot_out.first = rx;
            slot_out.seen = bit_m;
            slot_out.conf = '0;
            slot_out.emitted = (mode == rfqg_pkg::MODE_SHADOW);
            obs = bit_m;
            first = rx[62:0];
            if (mode == rfqg_pkg::MODE_SHADOW) begin
                outcome = rfqg_pkg::OUT_ACTIONABLE;
                agr = bit_m;
                ready = rx[62:0];
            end
        end else if (ev < ep) begin
            outcome = rfqg_pkg::OUT_STALE;
            obs = slot_in.seen;
        end else if ((slot_in.seen & bit_m) != 3'b000) begin
            first = slot_in.first[62:0];
            obs = slot_in.seen;
            if (rec_in[lane].bid != bid || rec_in[lane].ask != ask) begin
                slot_we = 1'b1;
                slot_out.conf = slot_in.conf | bit_m;
                outcome = rfqg_pkg::OUT_CONFLICT;
            end else begin
                outcome = rfqg_pkg::OUT_DUPLICATE;
            end
            con = slot_out.conf;
        end else begin
            slot_we = 1'b1;
            lane_we = 1'b1;
            first = slot_in.first[62:0];
            slot_out.seen = seen2;
            obs = seen2;
            if (mode == rfqg_pkg::MODE_SHADOW) begin
                if (bid == r[fl].bid && ask == r[fl].ask) begin
                    outcome = rfqg_pkg::OUT_DUPLICATE;
                    agr = best;
                end else begin
                    slot_out.conf = slot_in.conf | bit_m;
                    outcome = rfqg_pkg::OUT_CONFLICT;
                    con = slot_out.conf;
                end
            end else if (!slot_in.emitted && rfqg_pkg::count3(best) >= 2'd2) begin
                slot_out.emitted = 1'b1;
                obid = r[rr].bid;
                oask = r[rr].ask;
                outcome = rfqg_pkg::OUT_ACTIONABLE;
                agr = best;
                ready = rx[62:0];
            end else if (seen2 == 3'b111 && rfqg_pkg::count3(best) < 2'd2) begin
                slot_out.conf = seen2;
                outcome = rfqg_pkg::OUT_CONFLICT;
                con = seen2;
            end
        end
    end
endmodule

// ----- hdl/rfqg_checker.sv -----
// Port-level checker for the redundant feed quorum gate, with its bind.
// Depends on redundant_feed_quorum_gate_macros.svh and rfqg_pkg.
`include "redundant_feed_quorum_gate_macros.svh"
module rfqg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_outcome,
    input logic [2:0]  m_observed_mask,
    input logic [62:0] m_ready_time
);
    // Result held until taken
    `RFQG_ASSERT(a_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    // Waiting result keeps its payload
    `RFQG_ASSERT(a_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(m_outcome) && $stable(m_observed_mask))
    // Ready time only on actionable results
    `RFQG_ASSERT(a_ready_time, aclk, aresetn, m_valid && m_outcome != rfqg_pkg::OUT_ACTIONABLE |-> m_ready_time == 63'd0)
    // Rejected items show no lanes
    `RFQG_ASSERT(a_rej_mask, aclk, aresetn, m_valid && (m_outcome == rfqg_pkg::OUT_INVALID || m_outcome == rfqg_pkg::OUT_RANGE) |-> m_observed_mask == 3'd0)
endmodule

bind redundant_feed_quorum_gate rfqg_checker u_rfqg_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_outcome(m_outcome),
    .m_observed_mask(m_observed_mask), .m_ready_time(m_ready_time)
);
